/* rtl/cfa_pkg.sv */
// Shared types, codes and widths of the contiguous frame allocator.
// No dependencies; the interfaces, top level, config registers and sequencer import this package.
`default_nettype none

package cfa_pkg;

  localparam int BaseW    = 20;  // absolute frame numbers
  localparam int CountW   = 15;  // counts, pool size register, free counter
  localparam int StatusW  = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;

  localparam int MaxFramesDef = 16384;

  typedef enum logic [1:0] {
    OpAlloc   = 2'd0,
    OpRelease = 2'd1,
    OpMark    = 2'd2,
    OpInit    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk        = 3'd0,
    StNoSpace   = 3'd1,
    StNotInPool = 3'd2,
    StNotHead   = 3'd3,
    StBadCount  = 3'd4
  } status_e;

  // Per-frame state as stored in the table
  typedef enum logic [1:0] {
    FsFree  = 2'h0,
    FsUsed  = 2'h1,
    FsHead  = 2'h2,
    FsInacc = 2'h3
  } frame_state_e;

  localparam logic [CfgIdxW-1:0] RegPoolBase     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPoolFrames   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegInfoInternal = 2'd2;

  localparam logic [BaseW-1:0]  PoolBaseRst     = '0;
  localparam logic [CountW-1:0] PoolFramesRst   = 15'd16384;
  localparam logic              InfoInternalRst = 1'b1;

  typedef struct packed {
    logic [BaseW-1:0]  pool_base;
    logic [CountW-1:0] pool_frames;
    logic              info_internal;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [BaseW-1:0]  first_frame;
    logic [CountW-1:0] free_count;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/cfa_in_if.sv */
// Request channel of the frame allocator: operation, frame number, count.
// Depends on cfa_pkg.
`default_nettype none

interface cfa_in_if;
  logic                         valid;
  logic                         ready;
  cfa_pkg::op_e                 operation;
  logic [cfa_pkg::BaseW-1:0]    frame_number;
  logic [cfa_pkg::CountW-1:0]   count;

  modport source (output valid, operation, frame_number, count, input ready);
  modport sink   (input valid, operation, frame_number, count, output ready);
endinterface

`default_nettype wire

/* rtl/cfa_out_if.sv */
// Result channel of the frame allocator: status, first frame, free count.
// Depends on cfa_pkg.
`default_nettype none

interface cfa_out_if;
  logic                         valid;
  logic                         ready;
  cfa_pkg::status_e             status;
  logic [cfa_pkg::BaseW-1:0]    first_frame;
  logic [cfa_pkg::CountW-1:0]   free_count;

  modport source (output valid, status, first_frame, free_count, input ready);
  modport sink   (input valid, status, first_frame, free_count, output ready);
endinterface

`default_nettype wire

/* rtl/cfa_cfg_if.sv */
// Configuration write channel of the frame allocator: register index and data.
// Depends on cfa_pkg.
`default_nettype none

interface cfa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cfa_pkg::CfgIdxW-1:0]   index;
  logic [cfa_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/contiguous_frame_allocator.sv */
// Top level of the contiguous frame allocator: config registers, sequencer,
// frame-state RAM and result register. Depends on cfa_pkg, the cfa_*_if
// interfaces, cfa_cfg_regs, cfa_engine and cfa_ram.
//
//   channel  dir  handshake     payload
//   cfg_i    in   valid/ready   index (0 pool_base, 1 pool_frames, 2 info_internal), data
//   req_i    in   valid/ready   operation, frame_number, count
//   rsp_o    out  valid/ready   status, first_frame, free_count
//
// One item at a time. Initialize sweeps all MAX_FRAMES table entries,
// one a cycle, then gives its result. Allocate reads the first pool frame,
// scans for a run of count free frames and then writes that run, or gives
// its result once the scan reaches the pool end with no fit; release walks
// from the head, freeing it and the used frames after it, and stops for a
// frame that is not a head; mark writes the frames marked; items rejected
// before any table access go straight to the result. The single read and
// single write port of the table set this pace. Reset: the table is cleared
// by the same sweep, with no result; req_i.ready stays low during it,
// configuration writes are taken throughout. Stalls: a result waits in the
// output register; a held result blocks the sequencer only when the next one is ready to leave.
`default_nettype none

module contiguous_frame_allocator #(
  parameter int MAX_FRAMES = cfa_pkg::MaxFramesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cfa_cfg_if.sink   cfg_i,
  cfa_in_if.sink    req_i,
  cfa_out_if.source rsp_o
);
  import cfa_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);

  cfg_t          cfg_w;
  rsp_t          eng_rsp_w;
  logic          eng_valid_w;
  logic          eng_ready_w;
  logic          ram_we_w;
  logic [AW-1:0] ram_waddr_w;
  logic [1:0]    ram_wdata_w;
  logic [AW-1:0] ram_raddr_w;
  logic [1:0]    ram_rdata_w;

  // output register: valid is control, the payload needs no reset
  logic out_valid_q;
  rsp_t out_q;

  cfa_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg_w)
  );

  cfa_engine #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_w),
    .req_i       (req_i),
    .rsp_o       (eng_rsp_w),
    .rsp_valid_o (eng_valid_w),
    .rsp_ready_i (eng_ready_w),
    .ram_we_o    (ram_we_w),
    .ram_waddr_o (ram_waddr_w),
    .ram_wdata_o (ram_wdata_w),
    .ram_raddr_o (ram_raddr_w),
    .ram_rdata_i (ram_rdata_w)
  );

  // frame-state table, 2 bits per frame
  cfa_ram #(
    .Width (2),
    .Depth (MAX_FRAMES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we_w),
    .waddr_i (ram_waddr_w),
    .wdata_i (ram_wdata_w),
    .raddr_i (ram_raddr_w),
    .rdata_o (ram_rdata_w)
  );

  assign eng_ready_w = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_ready_w) begin
      out_valid_q <= eng_valid_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_ready_w && eng_valid_w) begin
      out_q <= eng_rsp_w;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.first_frame = out_q.first_frame;
  assign rsp_o.free_count  = out_q.free_count;

endmodule

`default_nettype wire

/* rtl/cfa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cfa_ram #(
  parameter int Width = 2,
  parameter int Depth = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/cfa_cfg_regs.sv */
// Pool configuration registers, written through the configuration channel.
// Depends on cfa_pkg and cfa_cfg_if.
`default_nettype none

module cfa_cfg_regs (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cfa_cfg_if.sink     cfg_i,
  output cfa_pkg::cfg_t cfg_o
);
  import cfa_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base     <= PoolBaseRst;
      cfg_q.pool_frames   <= PoolFramesRst;
      cfg_q.info_internal <= InfoInternalRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegPoolBase:     cfg_q.pool_base     <= cfg_i.data[BaseW-1:0];
        RegPoolFrames:   cfg_q.pool_frames   <= cfg_i.data[CountW-1:0];
        RegInfoInternal: cfg_q.info_internal <= cfg_i.data[0];
        default: ;  // unknown index: write is dropped
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/cfa_engine.sv */
// Sequencer of the frame allocator: clear sweep, first-fit scan, release walk
// and run writes over the frame-state RAM. Depends on cfa_pkg and cfa_in_if.
`default_nettype none

module cfa_engine #(
  parameter int MAX_FRAMES = cfa_pkg::MaxFramesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire cfa_pkg::cfg_t                 cfg_i,
  cfa_in_if.sink                             req_i,
  output      cfa_pkg::rsp_t                 rsp_o,
  output      logic                          rsp_valid_o,
  input  wire logic                          rsp_ready_i,
  output      logic                          ram_we_o,
  output      logic [$clog2(MAX_FRAMES)-1:0] ram_waddr_o,
  output      logic [1:0]                    ram_wdata_o,
  output      logic [$clog2(MAX_FRAMES)-1:0] ram_raddr_o,
  input  wire logic [1:0]                    ram_rdata_i
);
  import cfa_pkg::*;

  localparam int AW = $clog2(MAX_FRAMES);
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int CW = (NW > CountW) ? NW : CountW;
  localparam logic [NW-1:0] LastAddr = NW'(MAX_FRAMES - 1);

  typedef enum logic [2:0] {
    SClear, SIdle, SRead, SScan, SRel, SWrite, SDone
  } state_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [NW-1:0]     addr_q, addr_d;
  logic [NW-1:0]     run_q, run_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [NW-1:0]     left_q, left_d;
  frame_state_e      rest_q, rest_d;
  logic              first_q, first_d;
  logic              init_res_q, init_res_d;
  logic              init_used_q, init_used_d;
  logic [CountW-1:0] free_q, free_d;
  status_e           status_q, status_d;
  logic [BaseW-1:0]  frame_q, frame_d;

  logic [NW-1:0]     n_w;
  logic [BaseW-1:0]  off_w;
  logic              in_pool_w;
  logic [NW-1:0]     rel_w;
  logic [NW-1:0]     room_w;
  logic [NW-1:0]     addr_nx_w;
  logic [NW-1:0]     start_w;
  logic              used0_w;
  frame_state_e      rd_state_w;

  // pool size = min(pool_frames, MAX_FRAMES)
  assign n_w = (CW'(cfg_i.pool_frames) < CW'(MAX_FRAMES)) ? NW'(cfg_i.pool_frames)
                                                          : NW'(MAX_FRAMES);
  assign off_w     = req_i.frame_number - cfg_i.pool_base;
  assign in_pool_w = (req_i.frame_number >= cfg_i.pool_base) && (off_w < BaseW'(n_w));
  assign rel_w     = NW'(off_w);
  assign room_w    = n_w - rel_w;
  assign addr_nx_w = addr_q + NW'(1);
  assign start_w   = addr_nx_w - cnt_q;
  assign used0_w   = cfg_i.info_internal && (n_w != '0);
  assign rd_state_w = frame_state_e'(ram_rdata_i);

  assign req_i.ready = (state_q == SIdle);
  assign rsp_valid_o = (state_q == SDone);
  assign rsp_o       = '{status: status_q, first_frame: frame_q, free_count: free_q};

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    run_d       = run_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    rest_d      = rest_q;
    first_d     = first_q;
    init_res_d  = init_res_q;
    init_used_d = init_used_q;
    free_d      = free_q;
    status_d    = status_q;
    frame_d     = frame_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q[AW-1:0];
    ram_wdata_o = FsFree;
    ram_raddr_o = addr_q[AW-1:0];

    case (state_q)
      SClear: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = (addr_q == '0 && init_used_q) ? FsUsed : FsFree;
        addr_d      = addr_nx_w;
        if (addr_q == LastAddr) begin
          state_d = init_res_q ? SDone : SIdle;
        end
      end

      SIdle: begin
        if (req_i.valid) begin
          op_d     = req_i.operation;
          status_d = StOk;
          frame_d  = '0;
          first_d  = 1'b1;
          case (req_i.operation)
            OpInit: begin
              state_d     = SClear;
              addr_d      = '0;
              init_res_d  = 1'b1;
              init_used_d = used0_w;
              free_d      = CountW'(CW'(n_w) - CW'(used0_w));
            end
            OpAlloc: begin
              if (req_i.count == '0) begin
                status_d = StBadCount;
                state_d  = SDone;
              end else if (CW'(req_i.count) > CW'(n_w) || free_q == '0) begin
                status_d = StNoSpace;
                state_d  = SDone;
              end else begin
                addr_d  = '0;
                run_d   = '0;
                cnt_d   = NW'(req_i.count);
                state_d = SRead;
              end
            end
            default: begin  // release or mark
              if (!in_pool_w) begin
                status_d = StNotInPool;
                state_d  = SDone;
              end else if (req_i.operation == OpRelease) begin
                addr_d  = rel_w;
                state_d = SRead;
              end else if (req_i.count == '0) begin
                status_d = StBadCount;
                state_d  = SDone;
              end else begin
                addr_d  = rel_w;
                left_d  = (CW'(req_i.count) < CW'(room_w)) ? NW'(req_i.count) : room_w;
                rest_d  = FsInacc;
                state_d = SWrite;
              end
            end
          endcase
        end
      end

      // first read of a scan or walk; data shows up in the next state
      SRead: begin
        state_d = (op_q == OpAlloc) ? SScan : SRel;
      end

      SScan: begin
        ram_raddr_o = addr_nx_w[AW-1:0];
        if (rd_state_w == FsFree) begin
          run_d = run_q + NW'(1);
        end else begin
          run_d = '0;
        end
        if (rd_state_w == FsFree && run_q + NW'(1) == cnt_q) begin
          addr_d  = start_w;
          left_d  = cnt_q;
          rest_d  = FsUsed;
          frame_d = cfg_i.pool_base + BaseW'(start_w);
          state_d = SWrite;
        end else if (CW'(addr_nx_w) >= CW'(n_w)) begin
          status_d = StNoSpace;
          state_d  = SDone;
        end else begin
          addr_d = addr_nx_w;
        end
      end

      // walk: refuse a start that is not a head, else free the head, then each used frame after it up to the pool end
      SRel: begin
        ram_raddr_o = addr_nx_w[AW-1:0];
        first_d     = 1'b0;
        if (first_q && rd_state_w != FsHead) begin
          status_d = StNotHead;
          state_d  = SDone;
        end else if (first_q || rd_state_w == FsUsed) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = FsFree;
          if (CW'(free_q) < CW'(n_w)) begin
            free_d = free_q + CountW'(1);
          end
          if (CW'(addr_nx_w) >= CW'(n_w)) begin
            state_d = SDone;
          end else begin
            addr_d = addr_nx_w;
          end
        end else begin
          state_d = SDone;
        end
      end

      SWrite: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = first_q ? FsHead : rest_q;
        first_d     = 1'b0;
        addr_d      = addr_nx_w;
        left_d      = left_q - NW'(1);
        if (free_q != '0) begin
          free_d = free_q - CountW'(1);
        end
        if (left_q == NW'(1)) begin
          state_d = SDone;
        end
      end

      SDone: begin
        if (rsp_ready_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      op_q        <= OpInit;
      addr_q      <= '0;
      run_q       <= '0;
      cnt_q       <= '0;
      left_q      <= '0;
      rest_q      <= FsFree;
      first_q     <= 1'b0;
      init_res_q  <= 1'b0;
      init_used_q <= 1'b0;
      free_q      <= '0;
      status_q    <= StOk;
      frame_q     <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      addr_q      <= addr_d;
      run_q       <= run_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      rest_q      <= rest_d;
      first_q     <= first_d;
      init_res_q  <= init_res_d;
      init_used_q <= init_used_d;
      free_q      <= free_d;
      status_q    <= status_d;
      frame_q     <= frame_d;
    end
  end

  a_write_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SWrite |-> left_q != '0)
    else $error("run write with nothing left");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle || state_q == SDone || state_q == SRead) |-> !ram_we_o)
    else $error("table written outside a sweep, walk or run write");

  a_run_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SScan |-> run_q < cnt_q)
    else $error("scan run reached the request without stopping");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second item taken while one is in work");

endmodule

`default_nettype wire
